>>> rtl/core/kfs_pkg.sv
// ----------------------------------------------------------------------------
// kfs_pkg
// Shared types, codes and the key translation for the keypad key frame sender.
// ----------------------------------------------------------------------------
`default_nettype none

package kfs_pkg;

    localparam int KEY_DEPTH_DEF = 16;

    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_POLL  = 2'd1;
    localparam logic [1:0] CMD_PANEL = 2'd2;

    localparam logic REG_KEYPAD_ADDR = 1'b0;
    localparam logic REG_MAX_RETRIES = 1'b1;

    localparam logic [5:0] KEYPAD_ADDR_RST = 6'd16;
    localparam logic [3:0] MAX_RETRIES_RST = 4'd5;

    // command byte of a keypad poll, run through the ack check first
    localparam logic [7:0] POLL_BYTE = 8'hF6;
    localparam logic [4:0] RETRY_SAT = 5'd31;

    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_NINE  = 8'h39;
    localparam logic [7:0] ASC_HASH  = 8'h23;
    localparam logic [7:0] ASC_STAR  = 8'h2A;
    localparam logic [7:0] ASC_A     = 8'h41;
    localparam logic [7:0] ASC_D     = 8'h44;
    localparam logic [7:0] LETTER_OFS = 8'h25;
    localparam logic [4:0] CODE_HASH = 5'h0B;
    localparam logic [4:0] CODE_STAR = 5'h0A;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] key_code;
        logic [7:0] polled_addr;
        logic [7:0] panel_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        logic       ok;
        logic [4:0] code;
    } t_key_xlat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_CNT,
        ST_KEY,
        ST_SUM
    } t_state;

    function automatic t_key_xlat key_translate(input logic [7:0] k);
        t_key_xlat r;
        logic [7:0] d;
        logic [7:0] l;
        d      = k - ASC_ZERO;
        l      = k - LETTER_OFS;
        r.ok   = 1'b0;
        r.code = 5'd0;
        if (k >= ASC_ZERO && k <= ASC_NINE) begin
            r.ok   = 1'b1;
            r.code = d[4:0];
        end else if (k == ASC_HASH) begin
            r.ok   = 1'b1;
            r.code = CODE_HASH;
        end else if (k == ASC_STAR) begin
            r.ok   = 1'b1;
            r.code = CODE_STAR;
        end else if (k >= ASC_A && k <= ASC_D) begin
            r.ok   = 1'b1;
            r.code = l[4:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/keypad_key_frame_sender_unit.sv
// ----------------------------------------------------------------------------
// keypad_key_frame_sender_unit
// Buffers translated key pushes and sends them as a key frame when polled.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries key pushes, polls and other
// panel bytes. Output channel (o_out_valid / i_out_stall) carries the frame
// bytes, frame_last set on the checksum byte. Configuration goes through the
// APB port: keypad_addr at 0x0, max_retries at 0x4; pready is always high.
// A key push, a panel byte or a poll that sends nothing is not stalled and
// produces no item. A poll that sends a frame with N keys holds o_in_stall
// while header, count, N keys and checksum leave one per cycle unless the
// output stalls; the key buffer memory is read one entry per cycle, one
// entry ahead of the output register. Output stall stretches the frame by
// the stalled cycles. The output register decouples the sides: the next
// input item is taken while the checksum byte still waits at the output.
// Reset clears the key count, sequence, retry count, expected ack and the
// output valid, and loads the register defaults; buffer contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_key_frame_sender_unit
    import kfs_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = $clog2(KEY_DEPTH + 1);
    localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(KEY_DEPTH);

    logic [4:0]    key_mem [KEY_DEPTH];
    logic [4:0]    r_rd_data;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [1:0]    r_seq, n_seq;
    logic [4:0]    r_retry, n_retry;
    logic [7:0]    r_exp, n_exp;
    logic [7:0]    r_hdr, n_hdr;
    logic [7:0]    r_sum, n_sum;
    logic [5:0]    r_addr;
    logic [3:0]    r_max;
    logic          r_out_vld, n_out_vld;
    t_out_item     r_out, n_out;

    logic          in_acc;
    logic          out_free;
    logic          key_wr;
    logic [4:0]    key_wr_code;
    logic          cfg_wr;
    t_key_xlat     xl;
    logic          go_send;
    logic          ack_hit;
    logic [1:0]    seq_inc;
    logic [7:0]    cnt1;
    logic [CW-1:0] last_idx;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;
    assign xl       = key_translate(i_in_item.key_code);
    assign seq_inc  = r_seq + 2'd1;
    assign cnt1     = 8'(r_count) + 8'd1;
    assign last_idx = r_count - CW'(1);
    assign cfg_wr   = psel && penable && pwrite;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (go_send) n_state = ST_HDR;
            ST_HDR:  if (out_free) n_state = ST_CNT;
            ST_CNT:  if (out_free) n_state = ST_KEY;
            ST_KEY:  if (out_free && r_idx == last_idx) n_state = ST_SUM;
            ST_SUM:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_seq       = r_seq;
        n_retry     = r_retry;
        n_exp       = r_exp;
        n_hdr       = r_hdr;
        n_sum       = r_sum;
        n_out       = r_out;
        n_out_vld   = r_out_vld && i_out_stall;
        key_wr      = 1'b0;
        key_wr_code = xl.code;
        go_send     = 1'b0;
        ack_hit     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.cmd)
                        CMD_KEY: begin
                            if (xl.ok && r_count < DEPTH_C) begin
                                key_wr  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        CMD_POLL: begin
                            if (r_exp != 8'd0 && r_exp == POLL_BYTE) begin
                                ack_hit = 1'b1;
                                n_count = '0;
                                n_retry = '0;
                            end
                            n_exp = 8'd0;
                            if (!ack_hit && i_in_item.polled_addr == {2'b00, r_addr}
                                    && r_count != '0) begin
                                n_seq = seq_inc;
                                if (r_retry > {1'b0, r_max}) begin
                                    n_retry = '0;
                                    n_count = '0;
                                end else begin
                                    go_send = 1'b1;
                                    n_hdr   = {seq_inc, r_addr};
                                    n_exp   = {seq_inc, r_addr};
                                    n_idx   = '0;
                                    if (r_retry != RETRY_SAT) begin
                                        n_retry = r_retry + 5'd1;
                                    end
                                end
                            end
                        end
                        CMD_PANEL: begin
                            if (i_in_item.panel_byte != 8'd0 && r_exp != 8'd0) begin
                                if (i_in_item.panel_byte == r_exp) begin
                                    n_count = '0;
                                    n_retry = '0;
                                end
                                n_exp = 8'd0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_HDR: begin
                if (out_free) begin
                    n_out_vld        = 1'b1;
                    n_out.tx_byte    = r_hdr;
                    n_out.frame_last = 1'b0;
                    n_sum            = r_hdr;
                end
            end
            ST_CNT: begin
                if (out_free) begin
                    n_out_vld        = 1'b1;
                    n_out.tx_byte    = cnt1;
                    n_out.frame_last = 1'b0;
                    n_sum            = r_sum + cnt1;
                end
            end
            ST_KEY: begin
                if (out_free) begin
                    n_out_vld        = 1'b1;
                    n_out.tx_byte    = {3'b000, r_rd_data};
                    n_out.frame_last = 1'b0;
                    n_sum            = r_sum + {3'b000, r_rd_data};
                    n_idx            = r_idx + CW'(1);
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    n_out_vld        = 1'b1;
                    n_out.tx_byte    = 8'd0 - r_sum;
                    n_out.frame_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_seq     <= '0;
            r_retry   <= '0;
            r_exp     <= '0;
            r_out_vld <= 1'b0;
            r_addr    <= KEYPAD_ADDR_RST;
            r_max     <= MAX_RETRIES_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_seq     <= n_seq;
            r_retry   <= n_retry;
            r_exp     <= n_exp;
            r_out_vld <= n_out_vld;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_KEYPAD_ADDR: r_addr <= pwdata[5:0];
                    REG_MAX_RETRIES: r_max  <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_sum <= n_sum;
        r_out <= n_out;
    end

    // key buffer: written on accepted keys, read one entry ahead of the sender
    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            key_mem[r_count[AW-1:0]] <= key_wr_code;
        end
        if (n_idx < DEPTH_C) begin
            r_rd_data <= key_mem[n_idx[AW-1:0]];
        end
    end

    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            REG_KEYPAD_ADDR: prdata = {26'd0, r_addr};
            REG_MAX_RETRIES: prdata = {28'd0, r_max};
            default: ;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

>>> rtl/core/kfs_checker.sv
// ----------------------------------------------------------------------------
// kfs_checker
// Port-level checks on the keypad key frame sender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kfs_checker
    import kfs_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire t_in_item    i_in_item,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire t_out_item   o_out_item,
    input wire logic        pready
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // reset leaves nothing at the output
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    // only a poll can start a frame
    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.cmd != CMD_POLL |=> !$rose(o_out_valid))
        else $error("frame byte without poll");

    // key pushes never hold off the next item
    a_key_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_item.cmd == CMD_KEY |=> !o_in_stall)
        else $error("stall after key push");

endmodule

bind keypad_key_frame_sender_unit kfs_checker u_kfs_checker (.*);

`default_nettype wire
